FILE: sv/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

   localparam logic [31:0] SUM_STEP = 32'h9e37_79b9;

   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALG   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR   = 3'd5;

   // Algorithm and direction codes
   localparam logic ALG_TEA  = 1'b0;
   localparam logic ALG_XTEA = 1'b1;
   localparam logic DIR_ENC  = 1'b0;
   localparam logic DIR_DEC  = 1'b1;

   typedef struct packed {
      logic [3:0][WORD_W-1:0] key;
      logic                   alg;
      logic                   dir;
   } cfg_type;

   // a: word updated by the next half round, b: word it is updated from
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } word_pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/tea_round_cell.sv
`timescale 1ns / 1ps

module tea_round_cell
   import tea_pkg::*;
#(
   parameter int ROUND_COUNT = 32,
   parameter int STAGE = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  cfg_type       cfg,
   input  logic          in_valid,
   input  word_pair_type in_data,
   output logic          out_valid,
   output word_pair_type out_data
);

   localparam int ROUND = STAGE / 2;
   localparam int HALF  = STAGE % 2;

   localparam int M_TEA_ENC  = ROUND + 1;
   localparam int M_TEA_DEC  = ROUND_COUNT - ROUND;
   localparam int M_XTEA_ENC = ROUND + HALF;
   localparam int M_XTEA_DEC = ROUND_COUNT - ROUND - HALF;

   localparam logic [WORD_W-1:0] SUM_TEA_ENC  = 32'(64'(SUM_STEP) * 64'(M_TEA_ENC));
   localparam logic [WORD_W-1:0] SUM_TEA_DEC  = 32'(64'(SUM_STEP) * 64'(M_TEA_DEC));
   localparam logic [WORD_W-1:0] SUM_XTEA_ENC = 32'(64'(SUM_STEP) * 64'(M_XTEA_ENC));
   localparam logic [WORD_W-1:0] SUM_XTEA_DEC = 32'(64'(SUM_STEP) * 64'(M_XTEA_DEC));

   localparam logic HALF_BIT = 1'(HALF);

   logic                valid_ff;
   logic                valid_in;
   word_pair_type       data_ff;
   word_pair_type       data_in;
   logic                key_sel;
   logic [WORD_W-1:0]   sum;
   logic [1:0]          xkey_idx;
   logic [WORD_W-1:0]   f_tea;
   logic [WORD_W-1:0]   f_xtea;
   logic [WORD_W-1:0]   f_val;
   logic [WORD_W-1:0]   new_a;

   // Upper key pair / shifted key index on encrypt second half and decrypt first half
   assign key_sel = HALF_BIT ^ cfg.dir;

   always_comb begin
      case ({cfg.alg, cfg.dir})
         {ALG_TEA, DIR_ENC}:  sum = SUM_TEA_ENC;
         {ALG_TEA, DIR_DEC}:  sum = SUM_TEA_DEC;
         {ALG_XTEA, DIR_ENC}: sum = SUM_XTEA_ENC;
         {ALG_XTEA, DIR_DEC}: sum = SUM_XTEA_DEC;
         default:             sum = SUM_TEA_ENC;
      endcase
   end

   assign xkey_idx = key_sel ? sum[12:11] : sum[1:0];

   assign f_tea  = ((in_data.b << 4) + cfg.key[{key_sel, 1'b0}])
                 ^ (in_data.b + sum)
                 ^ ((in_data.b >> 5) + cfg.key[{key_sel, 1'b1}]);
   assign f_xtea = (((in_data.b << 4) ^ (in_data.b >> 5)) + in_data.b)
                 ^ (sum + cfg.key[xkey_idx]);
   assign f_val  = (cfg.alg == ALG_XTEA) ? f_xtea : f_tea;
   assign new_a  = (cfg.dir == DIR_DEC) ? (in_data.a - f_val) : (in_data.a + f_val);

   // Hand the updated word on as the source of the next half round
   always_comb begin
      valid_in  = advance ? in_valid : valid_ff;
      data_in   = data_ff;
      if (advance) begin
         data_in.a = in_data.b;
         data_in.b = new_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/tea_rsp_queue.sv
`timescale 1ns / 1ps

module tea_rsp_queue
   import tea_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  word_pair_type    push_data,
   input  logic             pop,
   output word_pair_type    head_data,
   output queue_status_type status
);

   localparam int DEPTH = 2;

   word_pair_type entry_ff [DEPTH];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'(DEPTH));
   assign status.empty = (count_ff == 2'd0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("response queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full response queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("response queue count did not follow push");

endmodule

FILE: sv/tea_xtea_block_cipher.sv
`timescale 1ns / 1ps
// An accepted item passes through every cell of the chain and then the result queue
//   before it shows on rsp_valid; a stall on the result side can hold it there.
// Throughput: one item per cycle unless held; each half round is one cell of the chain.
// Reset (synchronous): clears the key, algorithm and direction registers to zero,
//   empties the chain of cells and the two-entry result queue.

module tea_xtea_block_cipher
   import tea_pkg::*;
#(
   parameter int ROUND_COUNT = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data,
   // block input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WORD_W-1:0]      req_left_in,
   input  logic [WORD_W-1:0]      req_right_in,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_left_out,
   output logic [WORD_W-1:0]      rsp_right_out
);

   // Two half rounds per round, one cell each
   localparam int STAGES = 2 * ROUND_COUNT;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [3:0][WORD_W-1:0] key_ff;
   logic [3:0][WORD_W-1:0] key_in;
   logic                   alg_ff;
   logic                   alg_in;
   logic                   dir_ff;
   logic                   dir_in;
   cfg_type                cfg;

   always_comb begin
      key_in = key_ff;
      alg_in = alg_ff;
      dir_in = dir_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_KEY_0: key_in[0] = csr_data;
            CSR_KEY_1: key_in[1] = csr_data;
            CSR_KEY_2: key_in[2] = csr_data;
            CSR_KEY_3: key_in[3] = csr_data;
            CSR_ALG:   alg_in    = csr_data[0];
            CSR_DIR:   dir_in    = csr_data[0];
            default: begin
               // drop writes to unused indexes
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         alg_ff <= ALG_TEA;
         dir_ff <= DIR_ENC;
      end else begin
         key_ff <= key_in;
         alg_ff <= alg_in;
         dir_ff <= dir_in;
      end
   end

   assign cfg.key = key_ff;
   assign cfg.alg = alg_ff;
   assign cfg.dir = dir_ff;

   // ---------------------------------------------------------------
   // Chain of half-round cells
   // ---------------------------------------------------------------
   // Every cell updates word a from word b and hands the pair on swapped.
   // Encryption updates the left word first, decryption the right word first,
   // so decryption enters and leaves the chain with the two words exchanged.
   // After an even number of cells the words are back in entry order.
   logic                  pipe_advance;
   logic [STAGES:0]       valid_chain;
   word_pair_type         data_chain [STAGES+1];
   logic                  last_valid;
   word_pair_type         last_data;
   word_pair_type         result_data;

   logic                  queue_push;
   logic                  queue_pop;
   word_pair_type         queue_head;
   queue_status_type      queue_status;

   assign valid_chain[0]  = req_valid;
   assign data_chain[0].a = (dir_ff == DIR_DEC) ? req_right_in : req_left_in;
   assign data_chain[0].b = (dir_ff == DIR_DEC) ? req_left_in  : req_right_in;

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      tea_round_cell #(
         .ROUND_COUNT(ROUND_COUNT),
         .STAGE      (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (pipe_advance),
         .cfg      (cfg),
         .in_valid (valid_chain[g]),
         .in_data  (data_chain[g]),
         .out_valid(valid_chain[g+1]),
         .out_data (data_chain[g+1])
      );
   end

   assign last_valid = valid_chain[STAGES];
   assign last_data  = data_chain[STAGES];

   // Restore left/right order for decryption
   assign result_data.a = (dir_ff == DIR_DEC) ? last_data.b : last_data.a;
   assign result_data.b = (dir_ff == DIR_DEC) ? last_data.a : last_data.b;

   // The whole chain moves as one; it holds only when a finished item sits in
   // the last cell and the result queue has no room for it. This keeps
   // req_stall free of any path from rsp_stall.
   assign pipe_advance = !(last_valid && queue_status.full);
   assign req_stall    = !pipe_advance;

   // ---------------------------------------------------------------
   // Result queue: parts the chain from the result channel
   // ---------------------------------------------------------------
   assign queue_push = pipe_advance && last_valid;
   assign queue_pop  = rsp_valid && !rsp_stall;

   tea_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_data(result_data),
      .pop      (queue_pop),
      .head_data(queue_head),
      .status   (queue_status)
   );

   assign rsp_valid     = !queue_status.empty;
   assign rsp_left_out  = queue_head.a;
   assign rsp_right_out = queue_head.b;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(last_valid))
      else $error("last cell changed while chain was held");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (last_valid && rsp_valid))
      else $error("input held without a pending result");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |->
         (!rsp_valid && !req_stall && (valid_chain[STAGES:1] == '0)))
      else $error("block not empty after reset");

endmodule
